FILE: sv/local_alignment_score_assert.svh
// Assertion helpers for the alignment score RTL.
`ifndef LOCAL_ALIGNMENT_SCORE_ASSERT_SVH
`define LOCAL_ALIGNMENT_SCORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LAS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/las_pkg.sv
`timescale 1ns / 1ps

package las_pkg;

   // Input command codes.
   localparam logic CMD_QUERY  = 1'b0;
   localparam logic CMD_TARGET = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MATCH    = 2'd0;
   localparam logic [1:0] CSR_MISMATCH = 2'd1;
   localparam logic [1:0] CSR_GAP      = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [3:0]        MATCH_RESET    = 4'd2;
   localparam logic signed [4:0] MISMATCH_RESET = -5'sd1;
   localparam logic signed [4:0] GAP_RESET      = -5'sd1;

   // Control that travels with a wave along the cell chain.
   // A clear wave zeros the rows; a target wave carries one target symbol.
   typedef struct packed {
      logic       valid;
      logic       clr;
      logic       last;
      logic [7:0] symbol;
   } wave_type;

endpackage

FILE: sv/las_cell.sv
`timescale 1ns / 1ps

module las_cell #(
   parameter int SW    = 16,
   parameter int LW    = 7,
   parameter int INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [3:0]          match_score,
   input  logic signed [4:0]   mismatch_score,
   input  logic signed [4:0]   gap_score,
   input  logic [LW-1:0]       query_length,
   input  logic                load_en,
   input  logic [LW-1:0]       load_index,
   input  logic [7:0]          load_symbol,
   input  las_pkg::wave_type   wave_i,
   input  logic [SW-1:0]       h_left_i,
   input  logic signed [SW:0]  z_left_i,
   input  logic [SW-1:0]       diag_i,
   input  logic [SW-1:0]       rowmax_i,
   output las_pkg::wave_type   wave_o,
   output logic [SW-1:0]       h_o,
   output logic signed [SW:0]  z_o,
   output logic [SW-1:0]       diag_o,
   output logic [SW-1:0]       rowmax_o
);
   import las_pkg::*;

   localparam int AW = SW + 2;
   localparam logic [LW-1:0] MY_INDEX = LW'(INDEX);
   localparam logic signed [AW-1:0] SCORE_MAX = {2'b00, {SW{1'b1}}};
   localparam logic signed [AW-1:0] ZERO_X = '0;

   // Cell state: query symbol, score and vertical gap of this column.
   logic [7:0]         symbol_ff, symbol_in;
   logic [SW-1:0]      h_ff, h_in;
   logic signed [SW:0] v_ff, v_in;

   // Registered hand-off to the next cell.
   wave_type           wave_ff;
   logic [SW-1:0]      hout_ff, diag_ff, rowmax_ff, rowmax_in;
   logic signed [SW:0] zout_ff;

   logic               active;
   logic signed [AW-1:0] gap_x, up_x, vold_x, left_x, zleft_x, diag_x, s_x;
   logic signed [AW-1:0] v_a, v_b, v_new, z_a, z_b, z_new;
   logic signed [AW-1:0] d_x, m1, m2, h_raw, h_sat;
   logic [SW-1:0]      h_new;

   // Column update for the symbol passing through this cell.
   always_comb begin
      active  = MY_INDEX < query_length;
      gap_x   = AW'(gap_score);
      up_x    = $signed({2'b00, h_ff});
      vold_x  = AW'(v_ff);
      left_x  = $signed({2'b00, h_left_i});
      zleft_x = AW'(z_left_i);
      diag_x  = $signed({2'b00, diag_i});
      if (symbol_ff == wave_i.symbol) begin
         s_x = $signed({{(AW - 4){1'b0}}, match_score});
      end else begin
         s_x = AW'(mismatch_score);
      end
      v_a   = up_x + gap_x;
      v_b   = vold_x + gap_x;
      v_new = (v_a > v_b) ? v_a : v_b;
      z_a   = left_x + gap_x;
      z_b   = zleft_x + gap_x;
      z_new = (z_a > z_b) ? z_a : z_b;
      d_x   = diag_x + s_x;
      m1    = (d_x > v_new) ? d_x : v_new;
      m2    = (z_new > ZERO_X) ? z_new : ZERO_X;
      h_raw = (m1 > m2) ? m1 : m2;
      h_sat = (h_raw > SCORE_MAX) ? SCORE_MAX : h_raw;
      h_new = h_sat[SW-1:0];
   end

   // Next state of the column, of the query symbol and of the row maximum.
   always_comb begin
      h_in      = h_ff;
      v_in      = v_ff;
      symbol_in = symbol_ff;
      rowmax_in = rowmax_i;
      if (wave_i.valid && (wave_i.clr || wave_i.last)) begin
         h_in = '0;
         v_in = '0;
      end else if (wave_i.valid && active) begin
         h_in = h_new;
         v_in = v_new[SW:0];
      end
      if (active && !wave_i.clr && (h_new > rowmax_i)) begin
         rowmax_in = h_new;
      end
      if (load_en && (load_index == MY_INDEX)) begin
         symbol_in = load_symbol;
      end
   end

   // Column state and the whole wave reset; the payload registers do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff    <= '0;
         v_ff    <= '0;
         wave_ff <= '0;
      end else begin
         h_ff    <= h_in;
         v_ff    <= v_in;
         wave_ff <= wave_i;
      end
   end

   always_ff @(posedge clock) begin
      symbol_ff <= symbol_in;
      hout_ff   <= h_new;
      zout_ff   <= z_new[SW:0];
      diag_ff   <= h_ff;
      rowmax_ff <= rowmax_in;
   end

   assign wave_o   = wave_ff;
   assign h_o      = hout_ff;
   assign z_o      = zout_ff;
   assign diag_o   = diag_ff;
   assign rowmax_o = rowmax_ff;

endmodule

FILE: sv/local_alignment_score.sv
`timescale 1ns / 1ps
// Local alignment score engine, linear gap cost. Load the query with cmd 0
// beats (the first after a finished query or target starts a new query;
// symbols past QUERY_MAX are dropped), then stream target symbols with cmd 1
// beats. One beat is taken per clock cycle while busy is low. Each target
// symbol travels as a wave down a chain of QUERY_MAX cells, one cell per
// cycle. The best score of a target shows on rsp_best_score with a one-cycle
// rsp_valid strobe after the wave of its last beat passes the entry, cell
// and result registers. busy stays high from that beat up to the cycle the
// result shows, and is low in every other cycle. The result cannot be held
// off: sample it in the strobe cycle. No clearing pass is needed after reset.
`include "local_alignment_score_assert.svh"

module local_alignment_score #(
   parameter int QUERY_MAX   = 64,
   parameter int SCORE_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_cmd,
   input  logic [7:0]        req_symbol,
   input  logic              req_last,
   output logic              rsp_valid,
   output logic [15:0]       rsp_best_score,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [4:0]        csr_write_data
);
   import las_pkg::*;

   localparam int SW = SCORE_WIDTH;
   localparam int LW = $clog2(QUERY_MAX + 1);
   localparam logic [LW-1:0] QMAX = LW'(QUERY_MAX);

   // Configuration registers.
   logic [3:0]        match_ff;
   logic signed [4:0] mismatch_ff, gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff    <= MATCH_RESET;
         mismatch_ff <= MISMATCH_RESET;
         gap_ff      <= GAP_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_MATCH) begin
            match_ff <= csr_write_data[3:0];
         end
         if (csr_index == CSR_MISMATCH) begin
            mismatch_ff <= $signed(csr_write_data);
         end
         if (csr_index == CSR_GAP) begin
            gap_ff <= $signed(csr_write_data);
         end
      end
   end

   // Query bookkeeping and wave launch.
   logic          accept, new_query, load_en;
   logic [LW-1:0] qlen_ff, qlen_in, load_index;
   logic          open_ff, open_in, drain_ff, drain_in;
   wave_type      entry_ff, entry_in;

   // Chain links; index 0 feeds the first cell.
   wave_type           wave_c   [0:QUERY_MAX];
   logic [SW-1:0]      h_c      [0:QUERY_MAX];
   logic signed [SW:0] z_c      [0:QUERY_MAX];
   logic [SW-1:0]      diag_c   [0:QUERY_MAX];
   logic [SW-1:0]      rowmax_c [0:QUERY_MAX];

   wave_type      tail;
   logic [SW-1:0] best_ff, best_in, merged;
   logic [SW+15:0] best_ext;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_best_ff, rsp_best_in;

   assign accept = start && !busy;
   assign busy   = drain_ff;

   always_comb begin
      new_query  = accept && (req_cmd == CMD_QUERY) && !open_ff;
      load_en    = accept && (req_cmd == CMD_QUERY) && (new_query || (qlen_ff < QMAX));
      load_index = new_query ? '0 : qlen_ff;
      qlen_in    = qlen_ff;
      if (new_query) begin
         qlen_in = LW'(1);
      end else if (load_en) begin
         qlen_in = qlen_ff + LW'(1);
      end
      open_in = open_ff;
      if (accept) begin
         open_in = (req_cmd == CMD_QUERY) && !req_last;
      end
      // A new query sends a clear wave; a target symbol sends a target wave.
      entry_in.valid  = accept && ((req_cmd == CMD_TARGET) || new_query);
      entry_in.clr    = (req_cmd == CMD_QUERY);
      entry_in.last   = (req_cmd == CMD_TARGET) && req_last;
      entry_in.symbol = req_symbol;
      // Busy covers the flight of a final target symbol down the chain.
      drain_in = drain_ff;
      if (accept && (req_cmd == CMD_TARGET) && req_last) begin
         drain_in = 1'b1;
      end else if (tail.valid && tail.last) begin
         drain_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qlen_ff  <= '0;
         open_ff  <= 1'b0;
         drain_ff <= 1'b0;
         entry_ff <= '0;
      end else begin
         qlen_ff  <= qlen_in;
         open_ff  <= open_in;
         drain_ff <= drain_in;
         entry_ff <= entry_in;
      end
   end

   // Row start: column zero scores and gaps are zero.
   assign wave_c[0]   = entry_ff;
   assign h_c[0]      = '0;
   assign z_c[0]      = '0;
   assign diag_c[0]   = '0;
   assign rowmax_c[0] = '0;

   for (genvar j = 0; j < QUERY_MAX; j++) begin : g_cell
      las_cell #(
         .SW    (SW),
         .LW    (LW),
         .INDEX (j)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .match_score    (match_ff),
         .mismatch_score (mismatch_ff),
         .gap_score      (gap_ff),
         .query_length   (qlen_ff),
         .load_en        (load_en),
         .load_index     (load_index),
         .load_symbol    (req_symbol),
         .wave_i         (wave_c[j]),
         .h_left_i       (h_c[j]),
         .z_left_i       (z_c[j]),
         .diag_i         (diag_c[j]),
         .rowmax_i       (rowmax_c[j]),
         .wave_o         (wave_c[j+1]),
         .h_o            (h_c[j+1]),
         .z_o            (z_c[j+1]),
         .diag_o         (diag_c[j+1]),
         .rowmax_o       (rowmax_c[j+1])
      );
   end

   // Tail of the chain: fold each row maximum into the running best.
   assign tail = wave_c[QUERY_MAX];

   always_comb begin
      merged       = (rowmax_c[QUERY_MAX] > best_ff) ? rowmax_c[QUERY_MAX] : best_ff;
      best_ext     = {16'b0, merged};
      rsp_best_in  = best_ext[15:0];
      rsp_valid_in = tail.valid && !tail.clr && tail.last;
      best_in      = best_ff;
      if (tail.valid) begin
         best_in = (tail.clr || tail.last) ? '0 : merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_best_ff <= rsp_best_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_score = rsp_best_ff;

   // Checks on the launch, drain and tail logic.
   `LAS_ASSERT_NEXT(a_last_sets_busy, clock, reset,
      accept && (req_cmd == CMD_TARGET) && req_last, busy,
      "final target beat did not raise busy")
   `LAS_ASSERT_IMPLIES(a_rsp_after_busy, clock, reset,
      rsp_valid, $past(busy), "result beat without a preceding drain")
   `LAS_ASSERT_NEXT(a_rsp_single, clock, reset,
      rsp_valid, !rsp_valid, "result strobe lasted more than one cycle")
   `LAS_ASSERT_NEXT(a_clear_best, clock, reset,
      tail.valid && tail.clr, best_ff == '0, "clear wave left a running best")
   `LAS_ASSERT_IMPLIES(a_qlen_bound, clock, reset,
      1'b1, qlen_ff <= QMAX, "query length beyond the store depth")

endmodule

FILE: verif/local_alignment_score_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the alignment score engine, keeps its own copy of
// the query, the score rows and the scoring registers, and compares each
// result beat with the oldest predicted best score.
module local_alignment_score_checker #(
   parameter int QUERY_MAX   = 64,
   parameter int SCORE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_cmd,
   input  logic [7:0]  req_symbol,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic [15:0] rsp_best_score,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_write_data,
   output int          failure_count,
   output int          scores_pending
);
   import las_pkg::*;

   localparam int SCORE_MAX = (1 << SCORE_WIDTH) - 1;

   // Scoring registers as the block should hold them.
   logic [3:0]        match_pts;
   logic signed [4:0] mismatch_pts;
   logic signed [4:0] gap_pts;

   // Query and the previous row of the score matrix.
   logic [7:0] query_symbols [QUERY_MAX];
   int         query_len;
   bit         query_loading;
   int         row_score [QUERY_MAX];
   int         row_vgap [QUERY_MAX];
   int         best_so_far;

   logic [15:0] expected_scores [$];
   int          fails;

   initial begin
      failure_count  = 0;
      scores_pending = 0;
      fails          = 0;
   end

   function automatic int larger_of(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   function automatic void clear_matrix();
      for (int j = 0; j < QUERY_MAX; j++) begin
         row_score[j] = 0;
         row_vgap[j]  = 0;
      end
      best_so_far = 0;
   endfunction

   // One target symbol updates a whole row: vertical gap, horizontal gap and
   // the cell score, which is floored at zero and saturated at the top.
   function automatic void score_target_symbol(input logic [7:0] sym);
      int g;
      int diag;
      int left;
      int hgap;
      int up;
      int s;
      int v;
      int h;
      g    = int'(gap_pts);
      diag = 0;
      left = 0;
      hgap = 0;
      for (int j = 0; j < query_len; j++) begin
         up   = row_score[j];
         s    = (query_symbols[j] == sym) ? int'(match_pts) : int'(mismatch_pts);
         v    = larger_of(up + g, row_vgap[j] + g);
         hgap = larger_of(left + g, hgap + g);
         h    = larger_of(larger_of(diag + s, v), larger_of(hgap, 0));
         if (h > SCORE_MAX) begin
            h = SCORE_MAX;
         end
         row_vgap[j]  = v;
         row_score[j] = h;
         if (h > best_so_far) begin
            best_so_far = h;
         end
         diag = up;
         left = h;
      end
   endfunction

   // Effect of one accepted beat on the predicted state.
   function automatic void apply_beat(input logic cmd, input logic [7:0] sym,
                                      input logic fin);
      if (cmd == CMD_QUERY) begin
         // The first query beat after a closed query starts over.
         if (!query_loading) begin
            query_len     = 0;
            query_loading = 1'b1;
            clear_matrix();
         end
         // Symbols past the end of the store are dropped.
         if (query_len < QUERY_MAX) begin
            query_symbols[query_len] = sym;
            query_len++;
         end
         if (fin) begin
            query_loading = 1'b0;
         end
      end else begin
         query_loading = 1'b0;
         score_target_symbol(sym);
         if (fin) begin
            expected_scores.push_back(best_so_far[15:0]);
            clear_matrix();
         end
      end
   endfunction

   always @(posedge clock) begin : watch
      logic [15:0] predicted;
      if (reset) begin
         match_pts     = MATCH_RESET;
         mismatch_pts  = MISMATCH_RESET;
         gap_pts       = GAP_RESET;
         query_len     = 0;
         query_loading = 1'b0;
         for (int j = 0; j < QUERY_MAX; j++) begin
            query_symbols[j] = 8'd0;
         end
         clear_matrix();
         expected_scores.delete();
      end else begin
         // Register writes.
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MATCH: begin
                  match_pts = csr_write_data[3:0];
               end
               CSR_MISMATCH: begin
                  mismatch_pts = csr_write_data;
               end
               CSR_GAP: begin
                  gap_pts = csr_write_data;
               end
               default: begin
               end
            endcase
         end

         // A result beat is checked against the oldest prediction.
         if (rsp_valid) begin
            if (expected_scores.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, got %0d",
                        $time, rsp_best_score);
               fails++;
            end else begin
               predicted = expected_scores.pop_front();
               if (rsp_best_score !== predicted) begin
                  $display("%0t: best_score mismatch, expected %0d, got %0d",
                           $time, predicted, rsp_best_score);
                  fails++;
               end
            end
         end

         // An input beat is taken when start is high and busy is low.
         if (start && !busy) begin
            apply_beat(req_cmd, req_symbol, req_last);
         end
      end
      failure_count  <= fails;
      scores_pending <= expected_scores.size();
   end

endmodule

FILE: verif/tb_local_alignment_score.sv
`timescale 1ns / 1ps

module tb_local_alignment_score;
   import las_pkg::*;

   localparam int QUERY_MAX     = 64;
   localparam int SCORE_WIDTH   = 16;
   localparam int DRAIN_CYCLES  = QUERY_MAX + 6;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASE_ITEMS   = 260;

   typedef struct {
      logic [3:0]        match_pts;
      logic signed [4:0] mismatch_pts;
      logic signed [4:0] gap_pts;
   } score_setting_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        start            = 1'b0;
   logic        busy;
   logic        req_cmd          = CMD_QUERY;
   logic [7:0]  req_symbol       = 8'd0;
   logic        req_last         = 1'b0;
   logic        rsp_valid;
   logic [15:0] rsp_best_score;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index        = CSR_MATCH;
   logic [4:0]  csr_write_data   = 5'd0;

   int failure_count;
   int scores_pending;
   int cycle_count = 0;
   int burst_left  = 0;

   always #10 clock = ~clock;

   local_alignment_score #(
      .QUERY_MAX  (QUERY_MAX),
      .SCORE_WIDTH(SCORE_WIDTH)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_symbol      (req_symbol),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_best_score  (rsp_best_score),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   local_alignment_score_checker #(
      .QUERY_MAX  (QUERY_MAX),
      .SCORE_WIDTH(SCORE_WIDTH)
   ) score_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_symbol      (req_symbol),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_best_score  (rsp_best_score),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .failure_count   (failure_count),
      .scores_pending  (scores_pending)
   );

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Sends one beat and returns once it is taken and busy is low. Beats go out in
   // bursts of random length with idle gaps in between.
   task automatic send_beat(input logic cmd, input logic [7:0] sym, input logic fin);
      int gap;
      if (burst_left == 0) begin
         start <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      start      <= 1'b1;
      req_cmd    <= cmd;
      req_symbol <= sym;
      req_last   <= fin;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Holds off until every predicted score has come back and the cell chain
   // has had time to drain waves that give no result.
   task automatic wait_until_idle();
      start <= 1'b0;
      while (scores_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_register(input logic [1:0] index, input logic [4:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic load_setting(input score_setting_type setting);
      write_register(CSR_MATCH, {1'b0, setting.match_pts});
      write_register(CSR_MISMATCH, setting.mismatch_pts);
      write_register(CSR_GAP, setting.gap_pts);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Symbols mostly stay near a per-sequence base so that matches are common,
   // with some drawn from the whole byte range.
   function automatic logic [7:0] pick_symbol(input logic [7:0] base);
      if ($urandom_range(0, 3) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      return base ^ 8'($urandom_range(0, 3));
   endfunction

   // Sends a query or target of the given length, with last on the final
   // beat only when the sequence is to be closed.
   task automatic send_run(input logic cmd, input int len, input logic [7:0] base,
                           input logic closed);
      for (int i = 0; i < len; i++) begin
         send_beat(cmd, pick_symbol(base), closed && (i == len - 1));
      end
   endtask

   // Mostly well-formed queries followed by targets, with some noise beats
   // and sequences cut off by the other command.
   task automatic run_random_phase(input int quota);
      int sent;
      int kind;
      int qlen;
      int tlen;
      int targets;
      logic [7:0] base;
      sent = 0;
      while (sent < quota) begin
         kind = $urandom_range(0, 9);
         base = 8'($urandom_range(0, 255));
         if (kind < 8) begin
            qlen = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70)
                                               : $urandom_range(1, 12);
            send_run(CMD_QUERY, qlen, base, 1'b1);
            sent += (qlen < QUERY_MAX) ? qlen : QUERY_MAX;
            targets = $urandom_range(1, 3);
            for (int t = 0; t < targets; t++) begin
               tlen = $urandom_range(1, 12);
               send_run(CMD_TARGET, tlen, base, 1'b1);
               sent += tlen;
            end
         end else if (kind == 8) begin
            send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
            sent++;
         end else if ($urandom_range(0, 1) == 0) begin
            // Open query closed by a target.
            qlen = $urandom_range(1, 6);
            tlen = $urandom_range(1, 6);
            send_run(CMD_QUERY, qlen, base, 1'b0);
            send_run(CMD_TARGET, tlen, base, 1'b1);
            sent += qlen + tlen;
         end else begin
            // Partly streamed target dropped by a new query.
            tlen = $urandom_range(1, 5);
            qlen = $urandom_range(1, 4);
            send_run(CMD_TARGET, tlen, base, 1'b0);
            send_run(CMD_QUERY, qlen, base, 1'b1);
            send_run(CMD_TARGET, tlen, base, 1'b1);
            sent += 2 * tlen + qlen;
         end
      end
   endtask

   initial begin : stimulus
      score_setting_type settings [6];
      settings[0] = '{4'd15, -5'sd15, -5'sd15};
      settings[1] = '{4'd0, 5'sd0, 5'sd0};
      settings[2] = '{4'd15, 5'sd0, 5'sd0};
      settings[3] = '{4'd0, -5'sd15, -5'sd15};
      settings[4] = '{4'd5, -5'sd3, -5'sd2};
      settings[5] = '{4'($urandom_range(0, 15)), 5'(-$urandom_range(0, 15)),
                      5'(-$urandom_range(0, 15))};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Targets with no query loaded score zero.
      send_beat(CMD_TARGET, 8'h00, 1'b0);
      send_beat(CMD_TARGET, 8'hFF, 1'b1);

      // Exact match over the symbol extremes.
      send_beat(CMD_QUERY, 8'h00, 1'b0);
      send_beat(CMD_QUERY, 8'hFF, 1'b0);
      send_beat(CMD_QUERY, 8'h41, 1'b1);
      send_beat(CMD_TARGET, 8'h00, 1'b0);
      send_beat(CMD_TARGET, 8'hFF, 1'b0);
      send_beat(CMD_TARGET, 8'h41, 1'b1);

      // A query left open is closed by a target; the next query beat then
      // starts over and drops the partial target.
      send_beat(CMD_QUERY, 8'h41, 1'b0);
      send_beat(CMD_QUERY, 8'h42, 1'b0);
      send_beat(CMD_TARGET, 8'h41, 1'b0);
      send_beat(CMD_QUERY, 8'h10, 1'b1);
      send_beat(CMD_TARGET, 8'h10, 1'b1);

      // The query stays in place for a following target.
      send_beat(CMD_TARGET, 8'h7E, 1'b1);

      // Crossed symbols with mismatches and gaps.
      send_beat(CMD_QUERY, 8'h80, 1'b0);
      send_beat(CMD_QUERY, 8'h01, 1'b1);
      send_beat(CMD_TARGET, 8'h01, 1'b0);
      send_beat(CMD_TARGET, 8'h80, 1'b0);
      send_beat(CMD_TARGET, 8'h02, 1'b1);

      // Random phases, each under its own scoring setting.
      for (int p = 0; p < 6; p++) begin
         wait_until_idle();
         load_setting(settings[p]);
         run_random_phase(PHASE_ITEMS);
      end

      wait_until_idle();
      if (failure_count == 0 && scores_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+sv
sv/las_pkg.sv
sv/las_cell.sv
sv/local_alignment_score.sv
verif/local_alignment_score_checker.sv
verif/tb_local_alignment_score.sv
